// ----- hdl/thermal_runaway_monitor_defines.svh -----
// Assertion macros shared by the thermal runaway monitor RTL
`ifndef THERMAL_RUNAWAY_MONITOR_DEFINES_SVH
`define THERMAL_RUNAWAY_MONITOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TRM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/trm_pkg.sv -----
// Types and constants of the thermal runaway monitor
`default_nettype none
package trm_pkg;

    typedef enum logic [1:0] {
        FAULT_SAFE    = 2'd0,
        FAULT_OVER    = 2'd1,
        FAULT_UNDER   = 2'd2,
        FAULT_RUNAWAY = 2'd3
    } t_fault;

    typedef enum logic {
        OP_EVAL  = 1'b0,
        OP_CLEAR = 1'b1
    } t_op;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_TEMP = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_TEMP = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_RISE = 8'd3;

    localparam logic signed [15:0] RST_MAX_TEMP = 16'sd4800;
    localparam logic signed [15:0] RST_MIN_TEMP = 16'sd0;
    localparam logic [31:0]        RST_TIMEOUT  = 32'd60000;
    localparam logic [14:0]        RST_MIN_RISE = 15'd32;

    typedef struct packed {
        logic signed [15:0] max_temperature;
        logic signed [15:0] min_temperature;
        logic [31:0]        runaway_timeout_ms;
        logic [14:0]        minimum_rise;
    } t_cfg;

    typedef struct packed {
        t_op                operation;
        logic signed [15:0] measured_temperature;
        logic signed [15:0] setpoint_temperature;
        logic [7:0]         heater_duty;
        logic [15:0]        elapsed_ms;
    } t_item;

endpackage
`default_nettype wire

// ----- hdl/trm_cfg.sv -----
// Configuration register file of the thermal runaway monitor
`default_nettype none
module trm_cfg (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_valid,
    input  wire logic [trm_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  wire logic [trm_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output trm_pkg::t_cfg                             o_cfg
);

    trm_pkg::t_cfg r_cfg;
    trm_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                trm_pkg::REG_MAX_TEMP: n_cfg.max_temperature    = signed'(i_cfg_data[15:0]);
                trm_pkg::REG_MIN_TEMP: n_cfg.min_temperature    = signed'(i_cfg_data[15:0]);
                trm_pkg::REG_TIMEOUT:  n_cfg.runaway_timeout_ms = i_cfg_data[31:0];
                trm_pkg::REG_MIN_RISE: n_cfg.minimum_rise       = i_cfg_data[14:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_temperature    <= trm_pkg::RST_MAX_TEMP;
            r_cfg.min_temperature    <= trm_pkg::RST_MIN_TEMP;
            r_cfg.runaway_timeout_ms <= trm_pkg::RST_TIMEOUT;
            r_cfg.minimum_rise       <= trm_pkg::RST_MIN_RISE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- hdl/trm_eval.sv -----
// Sample evaluation and heating state of the thermal runaway monitor
`default_nettype none
`include "thermal_runaway_monitor_defines.svh"
module trm_eval (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_advance,
    input  wire trm_pkg::t_item  i_item,
    input  wire trm_pkg::t_cfg   i_cfg,
    output trm_pkg::t_fault      o_fault
);

    logic               r_heating_active;
    logic signed [15:0] r_baseline;
    logic [31:0]        r_heating_time_ms;

    logic               n_heating_active;
    logic signed [15:0] n_baseline;
    logic [31:0]        n_heating_time_ms;
    trm_pkg::t_fault    n_fault;

    logic signed [15:0] w_temp;
    logic signed [15:0] w_target;
    logic signed [15:0] w_max;
    logic signed [15:0] w_min;
    logic signed [15:0] w_base;
    logic [31:0]        w_time;
    logic [32:0]        w_sum;
    logic [31:0]        w_time_sat;
    logic signed [16:0] w_rise;
    logic signed [16:0] w_min_rise;
    logic               w_heat;
    logic               w_low_rise;
    logic               w_past_timeout;
    logic               w_past_half;

    always_comb begin
        w_temp         = i_item.measured_temperature;
        w_target       = i_item.setpoint_temperature;
        w_max          = i_cfg.max_temperature;
        w_min          = i_cfg.min_temperature;
        w_heat         = (w_target > 16'sd0) && i_item.heater_duty[7];
        w_base         = r_heating_active ? r_baseline : w_temp;
        w_time         = r_heating_active ? r_heating_time_ms : 32'd0;
        w_sum          = {1'b0, w_time} + {17'd0, i_item.elapsed_ms};
        w_time_sat     = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
        w_rise         = {w_temp[15], w_temp} - {w_base[15], w_base};
        w_min_rise     = signed'({2'b00, i_cfg.minimum_rise});
        w_low_rise     = w_rise < w_min_rise;
        w_past_timeout = w_time_sat > i_cfg.runaway_timeout_ms;
        w_past_half    = {w_time_sat, 1'b0} > {1'b0, i_cfg.runaway_timeout_ms};

        n_heating_active  = r_heating_active;
        n_baseline        = r_baseline;
        n_heating_time_ms = r_heating_time_ms;
        n_fault           = trm_pkg::FAULT_SAFE;

        if (i_item.operation == trm_pkg::OP_CLEAR) begin
            n_heating_active  = 1'b0;
            n_baseline        = 16'sd0;
            n_heating_time_ms = 32'd0;
        end else if (w_temp > w_max) begin
            n_fault = trm_pkg::FAULT_OVER;
        end else if (w_temp < w_min) begin
            n_fault = trm_pkg::FAULT_UNDER;
        end else if (w_heat) begin
            n_heating_active  = 1'b1;
            n_baseline        = w_base;
            n_heating_time_ms = w_time_sat;
            if (w_past_timeout && w_low_rise) begin
                n_fault = trm_pkg::FAULT_RUNAWAY;
            end else if (w_past_half && !w_low_rise) begin
                n_baseline        = w_temp;
                n_heating_time_ms = 32'd0;
            end
        end else begin
            n_heating_active  = 1'b0;
            n_heating_time_ms = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heating_active  <= 1'b0;
            r_baseline        <= 16'sd0;
            r_heating_time_ms <= 32'd0;
        end else if (i_advance) begin
            r_heating_active  <= n_heating_active;
            r_baseline        <= n_baseline;
            r_heating_time_ms <= n_heating_time_ms;
        end
    end

    assign o_fault = n_fault;

    `TRM_ASSERT_NEXT(a_clear_resets_state, i_clk, i_rst_n,
        i_advance && (i_item.operation == trm_pkg::OP_CLEAR),
        !r_heating_active && (r_heating_time_ms == 32'd0) && (r_baseline == 16'sd0),
        "clear request did not reset heating state")
    `TRM_ASSERT_NEXT(a_runaway_keeps_heating, i_clk, i_rst_n,
        i_advance && (n_fault == trm_pkg::FAULT_RUNAWAY),
        r_heating_active && (r_heating_time_ms != 32'd0),
        "runaway reported without active heating")
    `TRM_ASSERT_NOW(a_idle_timer_zero, i_clk, i_rst_n,
        !r_heating_active,
        r_heating_time_ms == 32'd0,
        "heating timer nonzero while heating inactive")

endmodule
`default_nettype wire

// ----- hdl/thermal_runaway_monitor.sv -----
// Top level of the thermal runaway monitor: handshakes and pipeline registers
// Usage:
//   Sample channel (i_in_valid/o_in_ready) carries one request per sample:
//   an operation (evaluate or clear), temperature, setpoint, duty and elapsed
//   time. Result channel (o_out_valid/i_out_ready) returns one fault code per
//   request, in order. Configuration channel (i_cfg_valid/o_cfg_ready) writes
//   the limit, timeout and minimum rise registers; it is always ready and is
//   to be used only while no request is in flight.
//   A request accepted into the input register has its result in the result
//   register once it advances, which waits while an earlier result is not taken.
//   Throughput: one request per cycle while results are taken, set by the
//   combinational evaluation between the input and result registers, which
//   also updates the heating state so the next request sees it.
//   Reset: clears both pipeline stages and the heating state, and loads the
//   registers with their defaults (4800, 0, 60000 ms, 32).
//   Stall: while the result is not taken, one more request is held in the
//   input register; after that o_in_ready drops until the result moves.
`default_nettype none
`include "thermal_runaway_monitor_defines.svh"
module thermal_runaway_monitor (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_operation,
    input  wire logic signed [15:0]                i_measured_temperature,
    input  wire logic signed [15:0]                i_setpoint_temperature,
    input  wire logic [7:0]                        i_heater_duty,
    input  wire logic [15:0]                       i_elapsed_ms,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [1:0]                             o_fault_code,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [trm_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [trm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic            r_in_valid;
    trm_pkg::t_item  r_item;
    logic            r_out_valid;
    trm_pkg::t_fault r_fault;

    logic            n_in_valid;
    logic            n_out_valid;

    logic            w_advance;
    logic            w_in_take;
    trm_pkg::t_fault w_fault;
    trm_pkg::t_cfg   w_cfg;

    assign o_cfg_ready = 1'b1;

    trm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    trm_eval u_eval (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (r_item),
        .i_cfg     (w_cfg),
        .o_fault   (w_fault)
    );

    always_comb begin
        w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
        o_in_ready  = !r_in_valid || w_advance;
        w_in_take   = i_in_valid && o_in_ready;
        n_in_valid  = w_in_take || (r_in_valid && !w_advance);
        n_out_valid = w_advance || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item.operation            <= trm_pkg::t_op'(i_operation);
            r_item.measured_temperature <= i_measured_temperature;
            r_item.setpoint_temperature <= i_setpoint_temperature;
            r_item.heater_duty          <= i_heater_duty;
            r_item.elapsed_ms           <= i_elapsed_ms;
        end
        if (w_advance) begin
            r_fault <= w_fault;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_fault_code = r_fault;

    `TRM_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n,
        !o_in_ready,
        r_in_valid && r_out_valid && !i_out_ready,
        "sample channel stalled with room in the pipeline")

endmodule
`default_nettype wire
